FILE: src/rmsb_pkg.sv
// shared types, codes and saturation helpers for the rms-norm backward row core
package rmsb_pkg;

   localparam int CNT_W = 7;
   localparam int OUT_W = 32;
   localparam int IDX_W = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA_EN = 2'd2;

   localparam logic [CNT_W-1:0] ROW_LENGTH_RST = 7'd64;
   localparam logic [CSR_DATA_W-1:0] EPSILON_RST = 16'd168;

   localparam logic [1:0] SH_0 = 2'd0;
   localparam logic [1:0] SH_16 = 2'd1;
   localparam logic [1:0] SH_28 = 2'd2;
   localparam logic [1:0] SH_36 = 2'd3;

   localparam int INV_W = 29;
   localparam int SQRT_TOP = 56;
   localparam int SQRT_STEPS = 29;
   localparam int DIV_STEPS = 64;

   localparam logic signed [63:0] INT64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic              start;
      logic [1:0]        shift;
      logic signed [63:0] a;
      logic signed [31:0] b;
   } mul_req_type;

   typedef struct packed {
      logic              done;
      logic signed [63:0] result;
   } mul_rsp_type;

   typedef struct packed {
      logic        start;
      logic        sqrt;
      logic [63:0] num;
      logic [63:0] den;
   } ds_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] result;
   } ds_rsp_type;

   function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'(INT64_MAX)) return INT64_MAX;
      if (s < -65'(INT64_MAX)) return -INT64_MAX;
      return s[63:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
      if (v > 65'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -65'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

endpackage

FILE: src/rmsb_ram.sv
// generic single-write, single-read ram with registered read data
module rmsb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/rmsb_mul.sv
// shared multi-cycle signed multiply with truncating shift and 64-bit saturation
module rmsb_mul import rmsb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type req,
   output mul_rsp_type rsp
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LO = 3'd1;
   localparam logic [2:0] ST_HI = 3'd2;
   localparam logic [2:0] ST_SUM = 3'd3;
   localparam logic [2:0] ST_OUT = 3'd4;

   logic [2:0]         step_ff;
   logic               done_ff;
   logic [63:0]        a_mag_ff;
   logic [31:0]        b_mag_ff;
   logic               neg_ff;
   logic [1:0]         sh_ff;
   logic [63:0]        prod_ff;
   logic [95:0]        acc_ff;
   logic signed [63:0] res_ff;

   logic [31:0] op_a;
   logic [63:0] mult;
   logic [5:0]  shamt;
   logic [95:0] shifted;
   logic [63:0] mag;

   assign op_a = (step_ff == ST_LO) ? a_mag_ff[31:0] : a_mag_ff[63:32];
   assign mult = 64'(op_a) * 64'(b_mag_ff);

   always_comb begin
      case (sh_ff)
         SH_16:   shamt = 6'd16;
         SH_28:   shamt = 6'd28;
         SH_36:   shamt = 6'd36;
         default: shamt = 6'd0;
      endcase
   end

   assign shifted = acc_ff >> shamt;
   assign mag = (shifted[95:63] != '0) ? 64'(INT64_MAX) : shifted[63:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (step_ff)
            ST_IDLE: begin
               if (req.start) step_ff <= ST_LO;
            end
            ST_LO:  step_ff <= ST_HI;
            ST_HI:  step_ff <= ST_SUM;
            ST_SUM: step_ff <= ST_OUT;
            ST_OUT: begin
               done_ff <= 1'b1;
               step_ff <= ST_IDLE;
            end
            default: step_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (step_ff == ST_IDLE && req.start) begin
         a_mag_ff <= req.a[63] ? 64'(-req.a) : 64'(req.a);
         b_mag_ff <= req.b[31] ? 32'(-req.b) : 32'(req.b);
         neg_ff   <= req.a[63] ^ req.b[31];
         sh_ff    <= req.shift;
      end
      if (step_ff == ST_LO) begin
         prod_ff <= mult;
      end
      if (step_ff == ST_HI) begin
         acc_ff  <= {32'd0, prod_ff};
         prod_ff <= mult;
      end
      if (step_ff == ST_SUM) begin
         acc_ff <= acc_ff + {prod_ff, 32'd0};
      end
      if (step_ff == ST_OUT) begin
         res_ff <= neg_ff ? -signed'(mag) : signed'(mag);
      end
   end

   assign rsp.done = done_ff;
   assign rsp.result = res_ff;

   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(step_ff) == ST_OUT)
      else $error("multiply done without finishing its steps");

endmodule

FILE: src/rmsb_divsqrt.sv
// shared bit-serial unsigned divider and integer square root
module rmsb_divsqrt import rmsb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  ds_req_type req,
   output ds_rsp_type rsp
);

   logic        busy_ff;
   logic        done_ff;
   logic        sqrt_ff;
   logic [6:0]  cnt_ff;
   logic [63:0] num_ff;
   logic [63:0] den_ff;
   logic [64:0] rem_ff;
   logic [63:0] q_ff;

   logic [64:0] rem_sh;
   logic        div_ge;
   logic [63:0] trial;
   logic        sq_ge;
   logic [6:0]  last_cnt;

   assign rem_sh = {rem_ff[63:0], num_ff[63]};
   assign div_ge = rem_sh >= {1'b0, den_ff};
   assign trial = q_ff + den_ff;
   assign sq_ge = num_ff >= trial;
   assign last_cnt = sqrt_ff ? 7'(SQRT_STEPS - 1) : 7'(DIV_STEPS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (!busy_ff) begin
            if (req.start) busy_ff <= 1'b1;
         end else if (cnt_ff == last_cnt) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!busy_ff) begin
         if (req.start) begin
            sqrt_ff <= req.sqrt;
            cnt_ff  <= '0;
            num_ff  <= req.num;
            den_ff  <= req.sqrt ? (64'd1 << SQRT_TOP) : req.den;
            rem_ff  <= '0;
            q_ff    <= '0;
         end
      end else begin
         cnt_ff <= cnt_ff + 7'd1;
         if (sqrt_ff) begin
            if (sq_ge) begin
               num_ff <= num_ff - trial;
               q_ff   <= (q_ff >> 1) + den_ff;
            end else begin
               q_ff <= q_ff >> 1;
            end
            den_ff <= den_ff >> 2;
         end else begin
            num_ff <= num_ff << 1;
            rem_ff <= div_ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
            q_ff   <= {q_ff[62:0], div_ge};
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.result = q_ff;

   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

endmodule

FILE: src/rms_norm_backward_row_core.sv
// rms-norm backward pass over one row: load, reciprocal square root, per-element emit
//
// Input beats (req_) carry one activation, upstream gradient and gamma element plus a
// flag that clears that element's gamma-gradient accumulator. Beats of a row are loaded
// one at a time; each is accepted while idle and then runs three products on the shared
// multiplier with req_stall high until the block returns to idle.
// After the row_length-th beat the block forms the reciprocal square root of mean square
// plus epsilon: three 64-step divisions, a 29-step square root and three products.
// It then emits one result beat (rsp_) per element in order, five products each with
// gamma gradient enabled, three without; all products go through the one multiplier.
// rsp_row_last marks the final beat of the row. A result register sits on the output,
// so the next element is computed while the previous beat waits; when the receiver
// stalls, the block holds in its emit step. A new row may start while the last beat
// still waits. The csr_ port is always ready; the user must see that it is written only
// while idle, as the block itself does not enforce this.
// Reset sets row length 64, epsilon 168, gamma gradient enabled, and zeroes all sums
// and gamma-gradient accumulators (per-entry valid bits, no clearing pass).
module rms_norm_backward_row_core import rmsb_pkg::*; #(
   parameter int MAX_ROW = 64,
   parameter int DATA_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_act_value,
   input  logic signed [DATA_WIDTH-1:0] req_upstream_grad,
   input  logic signed [DATA_WIDTH-1:0] req_scale_value,
   input  logic                         req_clear_scale_grad,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [OUT_W-1:0]      rsp_input_grad,
   output logic signed [OUT_W-1:0]      rsp_scale_grad,
   output logic [IDX_W-1:0]             rsp_element_index,
   output logic                         rsp_row_last,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data
);

   localparam int AW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
   localparam int SQ_W = 2 * DATA_WIDTH + 5;
   localparam int MEM_W = 3 * DATA_WIDTH + 1;

   localparam logic [5:0] S_IDLE = 6'd0;
   localparam logic [5:0] S_L_XX = 6'd1;
   localparam logic [5:0] S_L_XX_W = 6'd2;
   localparam logic [5:0] S_L_DG = 6'd3;
   localparam logic [5:0] S_L_DG_W = 6'd4;
   localparam logic [5:0] S_L_DGX = 6'd5;
   localparam logic [5:0] S_L_DGX_W = 6'd6;
   localparam logic [5:0] S_F_DIVN = 6'd7;
   localparam logic [5:0] S_F_DIVN_W = 6'd8;
   localparam logic [5:0] S_F_DIVQ = 6'd9;
   localparam logic [5:0] S_F_DIVQ_W = 6'd10;
   localparam logic [5:0] S_F_SQRT = 6'd11;
   localparam logic [5:0] S_F_SQRT_W = 6'd12;
   localparam logic [5:0] S_F_C1 = 6'd13;
   localparam logic [5:0] S_F_C1_W = 6'd14;
   localparam logic [5:0] S_F_C2 = 6'd15;
   localparam logic [5:0] S_F_C2_W = 6'd16;
   localparam logic [5:0] S_F_C3 = 6'd17;
   localparam logic [5:0] S_F_C3_W = 6'd18;
   localparam logic [5:0] S_F_CDIV = 6'd19;
   localparam logic [5:0] S_F_CDIV_W = 6'd20;
   localparam logic [5:0] S_E_RD = 6'd21;
   localparam logic [5:0] S_E_LAT = 6'd22;
   localparam logic [5:0] S_E_DG = 6'd23;
   localparam logic [5:0] S_E_DG_W = 6'd24;
   localparam logic [5:0] S_E_T1 = 6'd25;
   localparam logic [5:0] S_E_T1_W = 6'd26;
   localparam logic [5:0] S_E_T2 = 6'd27;
   localparam logic [5:0] S_E_T2_W = 6'd28;
   localparam logic [5:0] S_E_DX = 6'd29;
   localparam logic [5:0] S_E_DX_W = 6'd30;
   localparam logic [5:0] S_E_ADD = 6'd31;
   localparam logic [5:0] S_E_ADD_W = 6'd32;
   localparam logic [5:0] S_E_OUT = 6'd33;

   logic [5:0]             state_ff;
   logic [CNT_W-1:0]       row_length_ff;
   logic [CSR_DATA_W-1:0]  epsilon_ff;
   logic                   ggen_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [SQ_W-1:0]        sq_ff;
   logic signed [63:0]     ws_ff;
   logic signed [63:0]     tmp_ff;
   logic signed [63:0]     c_ff;
   logic [INV_W-1:0]       inv_ff;
   logic [AW-1:0]          k_ff;
   logic signed [DATA_WIDTH-1:0] x_ff, dy_ff, g_ff;
   logic signed [DATA_WIDTH-1:0] xe_ff, de_ff, ge_ff;
   logic signed [OUT_W-1:0] acc_e_ff;
   logic signed [63:0]     t1_ff;
   logic signed [OUT_W-1:0] dx_ff;
   logic signed [OUT_W-1:0] sg_ff;
   logic [MAX_ROW-1:0]     acc_valid_ff;
   logic                   rsp_valid_ff;
   logic signed [OUT_W-1:0] rsp_input_grad_ff;
   logic signed [OUT_W-1:0] rsp_scale_grad_ff;
   logic [IDX_W-1:0]       rsp_element_index_ff;
   logic                   rsp_row_last_ff;

   logic [CNT_W-1:0]       len_eff;
   logic                   in_accept;
   logic                   out_load;
   logic                   last_elem;
   logic [MEM_W-1:0]       mem_rd;
   logic [OUT_W-1:0]       acc_rd;
   logic                   acc_wr;
   logic signed [OUT_W-1:0] sg_new;
   logic [63:0]            v_new;
   mul_req_type            mul_req;
   mul_rsp_type            mul_rsp;
   ds_req_type             ds_req;
   ds_rsp_type             ds_rsp;

   rmsb_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   rmsb_divsqrt u_divsqrt (
      .clock (clock),
      .reset (reset),
      .req   (ds_req),
      .rsp   (ds_rsp)
   );

   rmsb_ram #(.WIDTH(MEM_W), .DEPTH(MAX_ROW)) u_row_ram (
      .clock   (clock),
      .wr_en   (in_accept),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data ({req_clear_scale_grad, req_scale_value, req_upstream_grad, req_act_value}),
      .rd_addr (k_ff),
      .rd_data (mem_rd)
   );

   rmsb_ram #(.WIDTH(OUT_W), .DEPTH(MAX_ROW)) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_wr),
      .wr_addr (k_ff),
      .wr_data (sg_new),
      .rd_addr (k_ff),
      .rd_data (acc_rd)
   );

   always_comb begin
      if (row_length_ff == '0) begin
         len_eff = CNT_W'(1);
      end else if (row_length_ff > CNT_W'(MAX_ROW)) begin
         len_eff = CNT_W'(MAX_ROW);
      end else begin
         len_eff = row_length_ff;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign in_accept = req_valid && !req_stall;
   assign out_load = !rsp_valid_ff || !rsp_stall;
   assign last_elem = (CNT_W'(k_ff) + CNT_W'(1)) == count_ff;
   assign acc_wr = (state_ff == S_E_ADD_W) && mul_rsp.done;
   assign sg_new = sat32(65'(add_sat64(64'(acc_e_ff), mul_rsp.result)));
   assign v_new = ds_rsp.result + 64'(epsilon_ff);
   assign csr_ready = 1'b1;

   always_comb begin
      mul_req = '0;
      unique case (state_ff)
         S_L_XX: begin
            mul_req = '{1'b1, SH_0, 64'(x_ff), 32'(x_ff)};
         end
         S_L_DG: begin
            mul_req = '{1'b1, SH_0, 64'(dy_ff), 32'(g_ff)};
         end
         S_L_DGX: begin
            mul_req = '{1'b1, SH_0, tmp_ff, 32'(x_ff)};
         end
         S_F_C1: begin
            mul_req = '{1'b1, SH_16, ws_ff, signed'(32'(inv_ff))};
         end
         S_F_C2, S_F_C3: begin
            mul_req = '{1'b1, SH_16, c_ff, signed'(32'(inv_ff))};
         end
         S_E_DG: begin
            mul_req = '{1'b1, SH_0, 64'(de_ff), 32'(ge_ff)};
         end
         S_E_T1, S_E_ADD: begin
            mul_req = '{1'b1, SH_28, tmp_ff, signed'(32'(inv_ff))};
         end
         S_E_T2: begin
            mul_req = '{1'b1, SH_36, c_ff, 32'(xe_ff)};
         end
         S_E_DX: begin
            mul_req = '{1'b1, SH_0, 64'(de_ff), 32'(xe_ff)};
         end
         default: mul_req = '0;
      endcase
   end

   always_comb begin
      ds_req = '0;
      unique case (state_ff)
         S_F_DIVN: ds_req = '{1'b1, 1'b0, 64'(sq_ff), 64'(count_ff)};
         S_F_DIVQ: ds_req = '{1'b1, 1'b0, 64'd1 << SQRT_TOP, 64'(tmp_ff)};
         S_F_SQRT: ds_req = '{1'b1, 1'b1, 64'(tmp_ff), 64'd0};
         S_F_CDIV: ds_req = '{1'b1, 1'b0, c_ff[63] ? 64'(-c_ff) : 64'(c_ff),
                              64'(count_ff)};
         default:  ds_req = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LENGTH_RST;
         epsilon_ff    <= EPSILON_RST;
         ggen_ff       <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROW_LENGTH: row_length_ff <= csr_data[CNT_W-1:0];
            CSR_EPSILON:    epsilon_ff <= csr_data;
            CSR_GAMMA_EN:   ggen_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         sq_ff        <= '0;
         ws_ff        <= '0;
         k_ff         <= '0;
         acc_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == S_E_OUT && out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (acc_wr) begin
            acc_valid_ff[k_ff] <= 1'b1;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (in_accept) begin
                  count_ff <= count_ff + CNT_W'(1);
                  state_ff <= S_L_XX;
               end
            end
            S_L_XX:  state_ff <= S_L_XX_W;
            S_L_XX_W: begin
               if (mul_rsp.done) begin
                  sq_ff    <= sq_ff + SQ_W'(mul_rsp.result);
                  state_ff <= S_L_DG;
               end
            end
            S_L_DG:  state_ff <= S_L_DG_W;
            S_L_DG_W: begin
               if (mul_rsp.done) state_ff <= S_L_DGX;
            end
            S_L_DGX: state_ff <= S_L_DGX_W;
            S_L_DGX_W: begin
               if (mul_rsp.done) begin
                  ws_ff    <= add_sat64(ws_ff, mul_rsp.result);
                  state_ff <= (count_ff < len_eff) ? S_IDLE : S_F_DIVN;
               end
            end
            S_F_DIVN: state_ff <= S_F_DIVN_W;
            S_F_DIVN_W: begin
               if (ds_rsp.done) state_ff <= S_F_DIVQ;
            end
            S_F_DIVQ: state_ff <= S_F_DIVQ_W;
            S_F_DIVQ_W: begin
               if (ds_rsp.done) state_ff <= S_F_SQRT;
            end
            S_F_SQRT: state_ff <= S_F_SQRT_W;
            S_F_SQRT_W: begin
               if (ds_rsp.done) state_ff <= S_F_C1;
            end
            S_F_C1: state_ff <= S_F_C1_W;
            S_F_C1_W: begin
               if (mul_rsp.done) state_ff <= S_F_C2;
            end
            S_F_C2: state_ff <= S_F_C2_W;
            S_F_C2_W: begin
               if (mul_rsp.done) state_ff <= S_F_C3;
            end
            S_F_C3: state_ff <= S_F_C3_W;
            S_F_C3_W: begin
               if (mul_rsp.done) state_ff <= S_F_CDIV;
            end
            S_F_CDIV: state_ff <= S_F_CDIV_W;
            S_F_CDIV_W: begin
               if (ds_rsp.done) begin
                  k_ff     <= '0;
                  state_ff <= S_E_RD;
               end
            end
            S_E_RD:  state_ff <= S_E_LAT;
            S_E_LAT: state_ff <= S_E_DG;
            S_E_DG:  state_ff <= S_E_DG_W;
            S_E_DG_W: begin
               if (mul_rsp.done) state_ff <= S_E_T1;
            end
            S_E_T1: state_ff <= S_E_T1_W;
            S_E_T1_W: begin
               if (mul_rsp.done) state_ff <= S_E_T2;
            end
            S_E_T2: state_ff <= S_E_T2_W;
            S_E_T2_W: begin
               if (mul_rsp.done) state_ff <= ggen_ff ? S_E_DX : S_E_OUT;
            end
            S_E_DX: state_ff <= S_E_DX_W;
            S_E_DX_W: begin
               if (mul_rsp.done) state_ff <= S_E_ADD;
            end
            S_E_ADD: state_ff <= S_E_ADD_W;
            S_E_ADD_W: begin
               if (mul_rsp.done) state_ff <= S_E_OUT;
            end
            S_E_OUT: begin
               if (out_load) begin
                  if (last_elem) begin
                     count_ff <= '0;
                     sq_ff    <= '0;
                     ws_ff    <= '0;
                     state_ff <= S_IDLE;
                  end else begin
                     k_ff     <= k_ff + AW'(1);
                     state_ff <= S_E_RD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (in_accept) begin
         x_ff  <= req_act_value;
         dy_ff <= req_upstream_grad;
         g_ff  <= req_scale_value;
      end
      if (mul_rsp.done && (state_ff == S_L_DG_W || state_ff == S_E_DG_W ||
                           state_ff == S_E_DX_W)) begin
         tmp_ff <= mul_rsp.result;
      end
      if (ds_rsp.done && state_ff == S_F_DIVN_W) begin
         tmp_ff <= (v_new == '0) ? 64'sd1 : signed'(v_new);
      end
      if (ds_rsp.done && state_ff == S_F_DIVQ_W) begin
         tmp_ff <= signed'(ds_rsp.result);
      end
      if (ds_rsp.done && state_ff == S_F_SQRT_W) begin
         inv_ff <= ds_rsp.result[INV_W-1:0];
      end
      if (mul_rsp.done && (state_ff == S_F_C1_W || state_ff == S_F_C2_W ||
                           state_ff == S_F_C3_W)) begin
         c_ff <= mul_rsp.result;
      end
      if (ds_rsp.done && state_ff == S_F_CDIV_W) begin
         c_ff <= c_ff[63] ? -signed'(ds_rsp.result) : signed'(ds_rsp.result);
      end
      if (state_ff == S_E_LAT) begin
         xe_ff    <= mem_rd[DATA_WIDTH-1:0];
         de_ff    <= mem_rd[2*DATA_WIDTH-1:DATA_WIDTH];
         ge_ff    <= mem_rd[3*DATA_WIDTH-1:2*DATA_WIDTH];
         acc_e_ff <= (mem_rd[3*DATA_WIDTH] || !acc_valid_ff[k_ff]) ? '0 : acc_rd;
      end
      if (mul_rsp.done && state_ff == S_E_T1_W) begin
         t1_ff <= mul_rsp.result;
      end
      if (mul_rsp.done && state_ff == S_E_T2_W) begin
         dx_ff <= sat32(65'(t1_ff) - 65'(mul_rsp.result));
         sg_ff <= '0;
      end
      if (acc_wr) begin
         sg_ff <= sg_new;
      end
      if (state_ff == S_E_OUT && out_load) begin
         rsp_input_grad_ff    <= dx_ff;
         rsp_scale_grad_ff    <= sg_ff;
         rsp_element_index_ff <= IDX_W'(k_ff);
         rsp_row_last_ff      <= last_elem;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_input_grad = rsp_input_grad_ff;
   assign rsp_scale_grad = rsp_scale_grad_ff;
   assign rsp_element_index = rsp_element_index_ff;
   assign rsp_row_last = rsp_row_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      in_accept |=> state_ff == S_L_XX)
      else $error("accepted beat did not start the load sequence");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ROW))
      else $error("element count beyond row capacity");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_E_OUT |-> CNT_W'(k_ff) < count_ff)
      else $error("emit index beyond loaded elements");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_E_OUT && out_load && last_elem) |=>
         (state_ff == S_IDLE && count_ff == '0 && rsp_valid_ff))
      else $error("row end did not return to idle");

   assert property (@(posedge clock) disable iff (reset)
      acc_wr |-> ggen_ff)
      else $error("gamma gradient written while disabled");

endmodule
